[rtl/core/cgtr_pkg.sv]
// Shared types, constants and font table of the clipped glyph text rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package cgtr_pkg;

  localparam int FRAME_W_DEF = 1024;
  localparam int FRAME_H_DEF = 1024;

  localparam int CFG_DW = 24;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_START_X     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_START_Y     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CLIP_WIDTH  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CLIP_HEIGHT = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TEXT_RGB    = 3'd6;

  localparam logic [23:0] TEXT_RGB_RST = 24'hECF0F8;

  localparam logic [16:0] GLYPH_ADVANCE = 17'd6;
  localparam logic [2:0]  GLYPH_LAST_COL = 3'd4;
  localparam logic [2:0]  GLYPH_LAST_ROW = 3'd6;
  localparam logic [7:0]  CODE_SPACE = 8'h20;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  localparam int JQ_DEPTH = 2;  // power of two
  localparam int JQ_AW    = $clog2(JQ_DEPTH);

  // row 0 first; within a row bit 4 is the leftmost column
  typedef logic [0:6][4:0] glyph_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic        is_pixel;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_rgba;
    logic [15:0] glyph_total;
    logic        halted;
    logic        last_of_char;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [11:0] clip_left;
    logic [11:0] clip_top;
    logic [12:0] clip_width;
    logic [12:0] clip_height;
    logic [23:0] text_rgb;
  } cfg_t;

  // one classified character handed from front to back
  typedef struct packed {
    glyph_t      glyph;
    logic [16:0] pen;
    logic        draw;
    logic [15:0] total;
    logic        halted;
  } job_t;

  // full 13-bit width on a 12-bit edge needs 14 bits
  function automatic logic [13:0] clip_right(input cfg_t c);
    clip_right = {2'b0, c.clip_left} + {1'b0, c.clip_width};
  endfunction

  function automatic logic [13:0] clip_bottom(input cfg_t c);
    clip_bottom = {2'b0, c.clip_top} + {1'b0, c.clip_height};
  endfunction

  // case fold, then font lookup; unknown codes give '?'
  function automatic glyph_t font_glyph(input logic [7:0] code);
    logic [7:0] uc;
    uc = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
    unique case (uc)
      8'h20: font_glyph = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
      8'h41: font_glyph = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42: font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43: font_glyph = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'h44: font_glyph = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'h45: font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46: font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47: font_glyph = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'h48: font_glyph = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49: font_glyph = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31};
      8'h4A: font_glyph = {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
      8'h4B: font_glyph = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'h4C: font_glyph = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4D: font_glyph = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4E: font_glyph = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4F: font_glyph = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50: font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h51: font_glyph = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'h52: font_glyph = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53: font_glyph = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h54: font_glyph = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h55: font_glyph = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56: font_glyph = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'h57: font_glyph = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'h58: font_glyph = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      8'h59: font_glyph = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h5A: font_glyph = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      8'h30: font_glyph = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: font_glyph = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h32: font_glyph = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      8'h33: font_glyph = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h34: font_glyph = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      8'h35: font_glyph = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      8'h36: font_glyph = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: font_glyph = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      8'h38: font_glyph = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: font_glyph = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      8'h2D: font_glyph = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      8'h5F: font_glyph = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
      8'h2E: font_glyph = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      8'h3A: font_glyph = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      default: font_glyph = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/core/cgtr_front.sv]
// Front end: takes characters, tracks pen, count and stop, emits classified jobs.
`timescale 1ns / 1ps
`default_nettype none
module cgtr_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire cgtr_pkg::cfg_t   cfg,
  input  wire              in_push,
  input  wire cgtr_pkg::in_item_t in_item,
  output logic             in_full,
  input  wire              q_full,
  output logic             q_push,
  output cgtr_pkg::job_t   q_job
);

  logic [16:0] pen_r, pen_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        stop_r, stop_nxt;

  logic [16:0] pen_eff;
  logic [15:0] cnt_eff;
  logic        stop_eff, stop_new, counts;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    pen_eff  = in_item.first ? {1'b0, cfg.start_x} : pen_r;
    cnt_eff  = in_item.first ? 16'd0 : cnt_r;
    stop_eff = in_item.first ? 1'b0 : stop_r;
    stop_new = stop_eff
            || (pen_eff >= {3'd0, cgtr_pkg::clip_right(cfg)})
            || (cfg.start_y >= {2'd0, cgtr_pkg::clip_bottom(cfg)});
    counts   = !stop_new && (in_item.char_code != cgtr_pkg::CODE_SPACE)
            && (cnt_eff != 16'hFFFF);
    cnt_nxt  = counts ? cnt_eff + 16'd1 : cnt_eff;
    pen_nxt  = stop_new ? pen_eff : pen_eff + cgtr_pkg::GLYPH_ADVANCE;
    stop_nxt = stop_new;

    q_job.glyph  = cgtr_pkg::font_glyph(in_item.char_code);
    q_job.pen    = pen_eff;
    q_job.draw   = !stop_new;
    q_job.total  = cnt_nxt;
    q_job.halted = stop_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else if (q_push) begin
      pen_r  <= pen_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/cgtr_jobq.sv]
// Short job queue between the front end and the pixel scanner.
`timescale 1ns / 1ps
`default_nettype none
module cgtr_jobq (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  wire cgtr_pkg::job_t push_job,
  output logic           full,
  input  wire            pop,
  output cgtr_pkg::job_t pop_job,
  output logic           empty
);

  localparam int AW = cgtr_pkg::JQ_AW;

  cgtr_pkg::job_t mem_r [cgtr_pkg::JQ_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == (AW+1)'(cgtr_pkg::JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/cgtr_back.sv]
// Back end: scans the 5x7 cell of each drawn job, emits clipped pixels and the closing item.
`timescale 1ns / 1ps
`default_nettype none
module cgtr_back #(
  parameter int FRAME_WIDTH  = cgtr_pkg::FRAME_W_DEF,
  parameter int FRAME_HEIGHT = cgtr_pkg::FRAME_H_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire cgtr_pkg::cfg_t cfg,
  input  wire                 q_empty,
  input  wire cgtr_pkg::job_t q_job,
  output logic                q_pop,
  output logic                out_empty,
  input  wire                 out_pop,
  output cgtr_pkg::out_item_t out_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  cgtr_pkg::job_t      job_r;
  logic [2:0]          row_r, row_nxt, col_r, col_nxt;
  logic                vld_r, vld_nxt;
  cgtr_pkg::out_item_t out_r, out_nxt;

  logic        adv, take, lit;
  logic [17:0] px;
  logic [16:0] py;

  assign adv       = !vld_r || out_pop;
  assign out_empty = !vld_r;
  assign out_item  = out_r;

  always_comb begin
    px  = {1'b0, job_r.pen} + {15'd0, col_r};
    py  = {1'b0, cfg.start_y} + {14'd0, row_r};
    lit = job_r.glyph[row_r][cgtr_pkg::GLYPH_LAST_COL - col_r]
       && (py < {3'd0, cgtr_pkg::clip_bottom(cfg)})
       && (px < {4'd0, cgtr_pkg::clip_right(cfg)})
       && (px >= {6'd0, cfg.clip_left})
       && (py >= {5'd0, cfg.clip_top})
       && (px < 18'(FRAME_WIDTH))
       && (py < 17'(FRAME_HEIGHT));
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    vld_nxt   = vld_r && !out_pop;
    out_nxt   = out_r;
    take      = 1'b0;

    unique case (state_r)
      ST_SCAN: begin
        if (adv) begin
          if (lit) begin
            vld_nxt              = 1'b1;
            out_nxt.is_pixel     = 1'b1;
            out_nxt.pixel_x      = px[11:0];
            out_nxt.pixel_y      = py[11:0];
            out_nxt.pixel_rgba   = {cfg.text_rgb, cgtr_pkg::ALPHA_OPAQUE};
            out_nxt.glyph_total  = job_r.total;
            out_nxt.halted       = 1'b0;
            out_nxt.last_of_char = 1'b0;
          end
          if (col_r == cgtr_pkg::GLYPH_LAST_COL) begin
            col_nxt = '0;
            if (row_r == cgtr_pkg::GLYPH_LAST_ROW) state_nxt = ST_CLOSE;
            else row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end
      ST_CLOSE: begin
        if (adv) begin
          vld_nxt              = 1'b1;
          out_nxt.is_pixel     = 1'b0;
          out_nxt.pixel_x      = '0;
          out_nxt.pixel_y      = '0;
          out_nxt.pixel_rgba   = '0;
          out_nxt.glyph_total  = job_r.total;
          out_nxt.halted       = job_r.halted;
          out_nxt.last_of_char = 1'b1;
          take                 = !q_empty;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        take = !q_empty;
      end
    endcase

    if (take) begin
      row_nxt   = '0;
      col_nxt   = '0;
      state_nxt = q_job.draw ? ST_SCAN : ST_CLOSE;
    end
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
    if (take) job_r <= q_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/clipped_glyph_text_rasterizer.sv]
// Top level of the clipped glyph text rasterizer: config registers, front, job queue, back.
// Usage:
//  - Input channel (in_push / in_full / in_item): one character item per accepted
//    push. first=1 reloads the pen from start_x and clears the count and stop flag.
//  - Result channel (out_empty / out_pop / out_item): queue-like; the oldest item
//    sits on out_item while out_empty is low and leaves on out_pop.
//    Each character gives its clipped pixel writes in row-major order, then one
//    closing item with last_of_char set, the glyph count and the stop flag.
//  - Config port: cfg_we writes cfg_data to register cfg_index at the clock edge.
//    Write only while no characters are in flight.
// Timing:
//  - The front end classifies a character in its accept cycle; the earliest
//    result reaches out_item through the job queue, the job register and the output register.
//  - The back end walks all 35 glyph cells, one per cycle while the output is not
//    stalled, then the closing item; a stopped character gets only the closing item.
//    The scanner sets the rate; a two-entry job queue lets input keep flowing meanwhile.
//  - When the receiver stalls, the output register holds and the scanner waits;
//    the queue then fills and in_full rises.
// Reset (rst_n low, synchronous): queues empty, pen, count and stop cleared,
// config back to its defaults (text color 0xECF0F8, everything else 0).
`timescale 1ns / 1ps
`default_nettype none
module clipped_glyph_text_rasterizer #(
  parameter int FRAME_WIDTH  = cgtr_pkg::FRAME_W_DEF,
  parameter int FRAME_HEIGHT = cgtr_pkg::FRAME_H_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  input  wire cgtr_pkg::in_item_t      in_item,
  output logic                         in_full,
  output logic                         out_empty,
  input  wire                          out_pop,
  output cgtr_pkg::out_item_t          out_item,
  input  wire                          cfg_we,
  input  wire [cgtr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [cgtr_pkg::CFG_DW-1:0]   cfg_data
);

  cgtr_pkg::cfg_t cfg_r;

  // job hand-off between front and back
  logic           fq_push, fq_full, bq_pop, bq_empty;
  cgtr_pkg::job_t fq_job, bq_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x     <= '0;
      cfg_r.start_y     <= '0;
      cfg_r.clip_left   <= '0;
      cfg_r.clip_top    <= '0;
      cfg_r.clip_width  <= '0;
      cfg_r.clip_height <= '0;
      cfg_r.text_rgb    <= cgtr_pkg::TEXT_RGB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgtr_pkg::REG_START_X:     cfg_r.start_x     <= cfg_data[15:0];
        cgtr_pkg::REG_START_Y:     cfg_r.start_y     <= cfg_data[15:0];
        cgtr_pkg::REG_CLIP_LEFT:   cfg_r.clip_left   <= cfg_data[11:0];
        cgtr_pkg::REG_CLIP_TOP:    cfg_r.clip_top    <= cfg_data[11:0];
        cgtr_pkg::REG_CLIP_WIDTH:  cfg_r.clip_width  <= cfg_data[12:0];
        cgtr_pkg::REG_CLIP_HEIGHT: cfg_r.clip_height <= cfg_data[12:0];
        cgtr_pkg::REG_TEXT_RGB:    cfg_r.text_rgb    <= cfg_data[23:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  cgtr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_job   (fq_job)
  );

  cgtr_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .push_job (fq_job),
    .full     (fq_full),
    .pop      (bq_pop),
    .pop_job  (bq_job),
    .empty    (bq_empty)
  );

  cgtr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (bq_empty),
    .q_job     (bq_job),
    .q_pop     (bq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
